// File: sv/wma_pkg.sv
// shared constants, payload types and stage control type for the weighted moving average
`default_nettype none

package wma_pkg;

  // sample and fixed point widths
  localparam int SAMPLE_BITS       = 16;
  localparam int FRAC_BITS         = 8;
  localparam int VALUE_BITS        = SAMPLE_BITS + FRAC_BITS;
  localparam int RAW_BITS          = VALUE_BITS - 1;
  localparam int AVG_BITS          = RAW_BITS - FRAC_BITS;
  localparam int WINDOW_LENGTH_DEF = 30;

  // function codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // input item
  typedef struct packed {
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [AVG_BITS-1:0] average;
    logic [RAW_BITS-1:0] raw_average;
    logic                holds_data;
  } out_item_t;

  // control that travels along the pipeline
  typedef struct packed {
    logic valid;
    logic bypass;
    logic holds;
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: sv/wma_ring.sv
// sample ring: one write port, one registered read port with write-first bypass
`default_nettype none

module wma_ring #(
  parameter int DEPTH = wma_pkg::WINDOW_LENGTH_DEF,
  parameter int WIDTH = wma_pkg::VALUE_BITS,
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [IW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, new data when the same entry is written
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/wma_update.sv
// window state update: ring, window total and weighted sum, first pipeline stage
`default_nettype none

module wma_update #(
  parameter int WINDOW_LENGTH = wma_pkg::WINDOW_LENGTH_DEF,
  localparam int D   = WINDOW_LENGTH * (WINDOW_LENGTH + 1) / 2,
  localparam int XPW = wma_pkg::RAW_BITS + $clog2(D + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_fire,
  input  wire wma_pkg::in_item_t            in_item,
  output wma_pkg::stage_ctl_t               s1_ctl,
  output logic [XPW-1:0]                    s1_x,
  output logic [wma_pkg::RAW_BITS-1:0]      s1_avg
);

  localparam int N   = WINDOW_LENGTH;
  localparam int VW  = wma_pkg::VALUE_BITS;
  localparam int IW  = (N > 1) ? $clog2(N) : 1;
  localparam int CW  = $clog2(N + 1);
  localparam int TW  = VW + CW;
  localparam int WSW = XPW + 1;

  localparam logic signed [TW-1:0]  N_T  = TW'(N);
  localparam logic signed [WSW-1:0] N_W  = WSW'(N);
  localparam logic signed [WSW-1:0] D_W  = WSW'(D);
  localparam logic        [IW-1:0]  LAST = IW'(N - 1);
  localparam logic        [CW-1:0]  FULL = CW'(N);

  // window state
  logic        [IW-1:0]  slot_r,  slot_nxt;
  logic        [CW-1:0]  slots_r, slots_nxt;
  logic signed [VW-1:0]  fill_r,  fill_nxt;
  logic signed [TW-1:0]  total_r, total_nxt;
  logic signed [WSW-1:0] wsum_r,  wsum_nxt;
  logic                  empty_r, empty_nxt;

  // stage one registers
  wma_pkg::stage_ctl_t          s1_ctl_r;
  logic [XPW-1:0]               s1_x_r;
  logic [wma_pkg::RAW_BITS-1:0] s1_avg_r;

  logic signed [VW-1:0]  v;
  logic signed [VW-1:0]  oldest;
  logic        [VW-1:0]  rd_data;
  logic signed [TW-1:0]  total_step;
  logic signed [WSW-1:0] wsum_step;
  logic        [IW-1:0]  slot_inc;
  logic        [CW-1:0]  slots_inc;
  logic                  is_clear;
  logic                  do_clear;
  logic                  do_fill;
  logic                  do_step;

  // decode the transfer
  assign v        = $signed({in_item.sample, {wma_pkg::FRAC_BITS{1'b0}}});
  assign is_clear = (in_item.func == wma_pkg::FUNC_CLEAR);
  assign do_clear = in_fire && is_clear;
  assign do_fill  = in_fire && !is_clear && empty_r;
  assign do_step  = in_fire && !is_clear && !empty_r;

  // oldest entry: unwritten slots read as the fill value
  assign oldest = (CW'(slot_r) < slots_r) ? $signed(rd_data) : fill_r;

  // incremental update of total and weighted sum
  assign total_step = total_r + TW'(v) - TW'(oldest);
  assign wsum_step  = wsum_r + WSW'(v) * N_W - WSW'(total_step);

  // ring pointers
  assign slot_inc  = (slot_r == LAST) ? '0 : IW'(slot_r + 1'b1);
  assign slots_inc = (slots_r == FULL) ? slots_r : CW'(slots_r + 1'b1);

  // next state
  always_comb begin
    slot_nxt  = slot_r;
    slots_nxt = slots_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    wsum_nxt  = wsum_r;
    empty_nxt = empty_r;
    if (do_clear) begin
      slot_nxt  = '0;
      slots_nxt = '0;
      fill_nxt  = '0;
      total_nxt = '0;
      wsum_nxt  = '0;
      empty_nxt = 1'b1;
    end else if (do_fill) begin
      slot_nxt  = '0;
      slots_nxt = '0;
      fill_nxt  = v;
      total_nxt = TW'(v) * N_T;
      wsum_nxt  = WSW'(v) * D_W;
      empty_nxt = 1'b0;
    end else if (do_step) begin
      slot_nxt  = slot_inc;
      slots_nxt = slots_inc;
      total_nxt = total_step;
      wsum_nxt  = wsum_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      slots_r <= '0;
      fill_r  <= '0;
      total_r <= '0;
      wsum_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      slot_r  <= slot_nxt;
      slots_r <= slots_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      wsum_r  <= wsum_nxt;
      empty_r <= empty_nxt;
    end
  end

  // ring of scaled samples, read ahead at the next slot
  wma_ring #(
    .DEPTH (N),
    .WIDTH (VW)
  ) u_ring (
    .clk   (clk),
    .we    (do_step),
    .waddr (slot_r),
    .wdata (v),
    .raddr (slot_nxt),
    .rdata (rd_data)
  );

  // stage one: control, then clamped dividend or the direct value on fill and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.valid <= 1'b0;
    end else if (en) begin
      s1_ctl_r.valid <= in_fire;
    end
    if (en) begin
      s1_ctl_r.bypass <= is_clear || empty_r;
      s1_ctl_r.holds  <= !is_clear;
      s1_avg_r        <= (is_clear || v[VW-1]) ? '0 : v[wma_pkg::RAW_BITS-1:0];
      s1_x_r          <= (!wsum_step[WSW-1] && (wsum_step != '0)) ?
                         wsum_step[XPW-1:0] : '0;
    end
  end

  assign s1_ctl = s1_ctl_r;
  assign s1_x   = s1_x_r;
  assign s1_avg = s1_avg_r;

endmodule

`default_nettype wire

// File: sv/wma_divide.sv
// constant divide by the weight total: reciprocal multiply, then one correction step
`default_nettype none

module wma_divide #(
  parameter int WINDOW_LENGTH = wma_pkg::WINDOW_LENGTH_DEF,
  localparam int D   = WINDOW_LENGTH * (WINDOW_LENGTH + 1) / 2,
  localparam int XPW = wma_pkg::RAW_BITS + $clog2(D + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire wma_pkg::stage_ctl_t          s1_ctl,
  input  wire logic [XPW-1:0]               s1_x,
  input  wire logic [wma_pkg::RAW_BITS-1:0] s1_avg,
  output wma_pkg::stage_ctl_t               res_ctl,
  output logic [wma_pkg::RAW_BITS-1:0]      res_raw
);

  localparam int RW = wma_pkg::RAW_BITS;
  localparam int PW = 2 * XPW + 1;

  // floor(2^XPW / D): quotient estimate is exact or one low
  localparam logic [63:0]    RECIP_FULL = (64'd1 << XPW) / 64'(D);
  localparam logic [XPW:0]   RECIP      = RECIP_FULL[XPW:0];
  localparam logic [XPW-1:0] DIV_K      = XPW'(D);

  wma_pkg::stage_ctl_t s2_ctl_r;
  logic [XPW-1:0]      s2_x_r;
  logic [RW-1:0]       s2_q0_r;
  logic [RW-1:0]       s2_avg_r;
  wma_pkg::stage_ctl_t res_ctl_r;
  logic [RW-1:0]       res_raw_r;

  logic [PW-1:0]  prod;
  logic [XPW-1:0] back;
  logic [XPW-1:0] rem;
  logic [RW-1:0]  quot;

  // reciprocal multiply
  assign prod = PW'(s1_x) * PW'(RECIP);

  // stage two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r.valid <= 1'b0;
    end else if (en) begin
      s2_ctl_r.valid <= s1_ctl.valid;
    end
    if (en) begin
      s2_ctl_r.bypass <= s1_ctl.bypass;
      s2_ctl_r.holds  <= s1_ctl.holds;
      s2_x_r          <= s1_x;
      s2_q0_r         <= prod[XPW +: RW];
      s2_avg_r        <= s1_avg;
    end
  end

  // correction: bump the estimate when the remainder reaches the divisor
  assign back = XPW'(s2_q0_r) * DIV_K;
  assign rem  = s2_x_r - back;
  assign quot = (rem >= DIV_K) ? RW'(s2_q0_r + 1'b1) : s2_q0_r;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_ctl_r.valid <= 1'b0;
    end else if (en) begin
      res_ctl_r.valid <= s2_ctl_r.valid;
    end
    if (en) begin
      res_ctl_r.bypass <= s2_ctl_r.bypass;
      res_ctl_r.holds  <= s2_ctl_r.holds;
      res_raw_r        <= s2_ctl_r.bypass ? s2_avg_r : quot;
    end
  end

  assign res_ctl = res_ctl_r;
  assign res_raw = res_raw_r;

endmodule

`default_nettype wire

// File: sv/weighted_moving_average.sv
// top level of the linearly weighted moving average
//
// Input channel in_valid/in_ready/in_data carries func and a signed sample.
// func add takes a sample, func clear empties the averager. Every transfer
// gives exactly one result on out_valid/out_ready/out_data: the average with
// 8 fraction bits (raw_average), its integer part (average) and holds_data.
// The first sample after a clear fills the whole window with its value.
// From input transfer to out_valid, the window state and weighted sum
// update in the transfer cycle, then a reciprocal multiply stage and a
// correction stage feed the result register. Throughput is one item per
// cycle unless the receiver stalls; the state update is a recurrence and
// the divide by the weight total is pipelined behind it.
// When the receiver stalls the whole pipeline holds and in_ready follows
// out_ready while a result waits, so no result is dropped or repeated.
// Synchronous reset (rst_n low) empties the averager and drops all results
// in flight; the ring needs no clearing pass since slots that were never
// written read as the fill value.
`default_nettype none

module weighted_moving_average #(
  parameter int WINDOW_LENGTH = wma_pkg::WINDOW_LENGTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire wma_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wma_pkg::out_item_t      out_data
);

  localparam int D   = WINDOW_LENGTH * (WINDOW_LENGTH + 1) / 2;
  localparam int XPW = wma_pkg::RAW_BITS + $clog2(D + 1);

  wma_pkg::stage_ctl_t          s1_ctl;
  wma_pkg::stage_ctl_t          res_ctl;
  logic [XPW-1:0]               s1_x;
  logic [wma_pkg::RAW_BITS-1:0] s1_avg;
  logic [wma_pkg::RAW_BITS-1:0] res_raw;
  logic                         en;
  logic                         in_fire;

  // pipeline advances when the result register is free or being taken
  assign en       = !res_ctl.valid || out_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && en;

  wma_update #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_update (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_fire (in_fire),
    .in_item (in_data),
    .s1_ctl  (s1_ctl),
    .s1_x    (s1_x),
    .s1_avg  (s1_avg)
  );

  wma_divide #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_divide (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .s1_ctl  (s1_ctl),
    .s1_x    (s1_x),
    .s1_avg  (s1_avg),
    .res_ctl (res_ctl),
    .res_raw (res_raw)
  );

  // result packing
  assign out_valid            = res_ctl.valid;
  assign out_data.average     = res_raw[wma_pkg::RAW_BITS-1:wma_pkg::FRAC_BITS];
  assign out_data.raw_average = res_raw;
  assign out_data.holds_data  = res_ctl.holds;

endmodule

`default_nettype wire

// File: sv/wma_checker.sv
// port-level checks for the weighted moving average, bound to the top level
`default_nettype none

module wma_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire wma_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire wma_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input is only held off by a waiting result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // integer part matches the raw value
  a_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.average ==
                  out_data.raw_average[wma_pkg::RAW_BITS-1:wma_pkg::FRAC_BITS])
    else $error("average does not match raw average");

  // an empty averager reports zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.holds_data |-> out_data.raw_average == '0)
    else $error("empty averager gave a nonzero result");

  // a clear transfer comes out as an empty result when nothing stalls
  a_clear_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == wma_pkg::FUNC_CLEAR)
      ##1 out_ready ##1 out_ready |=> out_valid && !out_data.holds_data)
    else $error("clear result missing after pipeline latency");

endmodule

bind weighted_moving_average wma_checker u_wma_checker (.*);

`default_nettype wire

// File: test/weighted_moving_average_tb.sv
// testbench for the weighted moving average: random paced traffic checked against a predictor
`default_nettype none

module weighted_moving_average_tb;

  localparam int WLEN         = wma_pkg::WINDOW_LENGTH_DEF;
  localparam int WEIGHT_TOTAL = WLEN * (WLEN + 1) / 2;
  localparam int TOTAL_BITS   = wma_pkg::VALUE_BITS + 5;
  localparam int WSUM_BITS    = wma_pkg::VALUE_BITS + 9;
  localparam int PHASE_ITEMS  = 350;

  // predicts each average and checks the results in transfer order
  class average_tracker;
    logic signed [wma_pkg::VALUE_BITS-1:0] ring [WLEN];
    logic signed [wma_pkg::VALUE_BITS-1:0] fill_level;
    logic signed [TOTAL_BITS-1:0]          window_sum;
    logic signed [WSUM_BITS-1:0]           weighted_acc;
    longint                                level_avg;
    int                                    next_slot;
    int                                    filled_slots;
    bit                                    empty;
    wma_pkg::out_item_t                    expected_averages[$];
    int                                    adds;
    int                                    clears;
    int                                    checked;
    int                                    wraps;
    int                                    errors;

    function new();
      empty_window();
      adds    = 0;
      clears  = 0;
      checked = 0;
      wraps   = 0;
      errors  = 0;
    endfunction

    // ring contents are left alone, unwritten slots read as the fill level
    function void empty_window();
      next_slot    = 0;
      filled_slots = 0;
      fill_level   = '0;
      window_sum   = '0;
      weighted_acc = '0;
      level_avg    = 0;
      empty        = 1'b1;
    endfunction

    function int pending();
      return expected_averages.size();
    endfunction

    function void note_sample_transfer(wma_pkg::in_item_t item);
      logic signed [wma_pkg::VALUE_BITS-1:0] v;
      logic signed [wma_pkg::VALUE_BITS-1:0] oldest;
      wma_pkg::out_item_t                    res;
      if (item.func == wma_pkg::FUNC_CLEAR) begin
        clears++;
        empty_window();
      end else begin
        adds++;
        v = {item.sample, {wma_pkg::FRAC_BITS{1'b0}}};
        if (empty) begin
          // first sample fills the whole window
          fill_level   = v;
          window_sum   = v * WLEN;
          weighted_acc = v * WEIGHT_TOTAL;
          next_slot    = 0;
          filled_slots = 0;
          level_avg    = v;
        end else begin
          // replace the oldest entry and update both sums
          oldest       = (next_slot < filled_slots) ? ring[next_slot] : fill_level;
          window_sum   = window_sum + v - oldest;
          ring[next_slot] = v;
          if (filled_slots < WLEN) filled_slots++;
          if (next_slot == WLEN - 1) begin
            next_slot = 0;
            wraps++;
          end else begin
            next_slot++;
          end
          weighted_acc = weighted_acc + v * WLEN - window_sum;
          level_avg    = (weighted_acc > 0) ? longint'(weighted_acc) / WEIGHT_TOTAL : 0;
        end
        empty = 1'b0;
        if (level_avg < 0) level_avg = 0;
      end
      res.raw_average = level_avg[wma_pkg::RAW_BITS-1:0];
      res.average     = level_avg[wma_pkg::RAW_BITS-1:wma_pkg::FRAC_BITS];
      res.holds_data  = !empty;
      expected_averages.push_back(res);
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_average_transfer(wma_pkg::out_item_t got);
      wma_pkg::out_item_t want;
      if (expected_averages.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual avg %0d raw %0d holds %0d",
                 $time, got.average, got.raw_average, got.holds_data);
        return;
      end
      want = expected_averages.pop_front();
      checked++;
      compare_field("average", want.average, got.average);
      compare_field("raw_average", want.raw_average, got.raw_average);
      compare_field("holds_data", want.holds_data, got.holds_data);
    endfunction
  endclass

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  wma_pkg::in_item_t  in_data   = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  wma_pkg::out_item_t out_data;

  int gap_pct   = 0;
  int stall_pct = 0;
  int trend     = 16000;
  int gap_plan[4]   = '{0, 66, 0, 8};
  int stall_plan[4] = '{0, 0, 66, 8};

  average_tracker sb;

  weighted_moving_average dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watch both channels for transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_sample_transfer(in_data);
      if (out_valid && out_ready) sb.check_average_transfer(out_data);
    end
  end

  // mix of extremes, small values, full random and a drifting level
  function automatic logic signed [wma_pkg::SAMPLE_BITS-1:0] draw_sample();
    int s;
    case ($urandom_range(9))
      0: s = 32767;
      1: s = -32768;
      2, 3: s = int'($urandom_range(65535)) - 32768;
      4: s = int'($urandom_range(64)) - 32;
      default: begin
        s = trend + int'($urandom_range(1024)) - 512;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        trend = s;
      end
    endcase
    return s[wma_pkg::SAMPLE_BITS-1:0];
  endfunction

  // hold the transfer until accepted, with random gaps ahead of it
  task automatic send_item(input wma_pkg::in_item_t item);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_op(input logic func,
                         input logic signed [wma_pkg::SAMPLE_BITS-1:0] sample);
    wma_pkg::in_item_t item;
    item.func   = func;
    item.sample = sample;
    send_item(item);
  endtask

  // sender pauses until every outstanding result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // mostly sample runs long enough to wrap the ring, broken up by clears
  task automatic run_random(input int count);
    wma_pkg::in_item_t item;
    repeat (count) begin
      item.func   = wma_pkg::FUNC_ADD;
      item.sample = draw_sample();
      if ($urandom_range(59) == 0) begin
        item.func = wma_pkg::FUNC_CLEAR;
        trend     = $urandom_range(32767);
      end
      send_item(item);
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: clear when empty, extreme fills, negative clamp, ignored clear sample
    send_op(wma_pkg::FUNC_CLEAR, 16'sd0);
    send_op(wma_pkg::FUNC_ADD, 16'sd32767);
    send_op(wma_pkg::FUNC_ADD, -16'sd32768);
    send_op(wma_pkg::FUNC_ADD, -16'sd32768);
    send_op(wma_pkg::FUNC_CLEAR, 16'h5A5A);
    send_op(wma_pkg::FUNC_ADD, -16'sd32768);
    send_op(wma_pkg::FUNC_ADD, 16'sd32767);
    send_op(wma_pkg::FUNC_ADD, -16'sd1);
    send_op(wma_pkg::FUNC_CLEAR, 16'hFFFF);
    send_op(wma_pkg::FUNC_CLEAR, 16'h8000);
    send_op(wma_pkg::FUNC_ADD, 16'sd0);
    send_op(wma_pkg::FUNC_ADD, 16'sd1);
    send_op(wma_pkg::FUNC_ADD, 16'h5555);
    send_op(wma_pkg::FUNC_ADD, 16'hAAAA);
    send_op(wma_pkg::FUNC_CLEAR, 16'sd0);
    send_op(wma_pkg::FUNC_ADD, 16'sd1);
    send_op(wma_pkg::FUNC_ADD, 16'sd32767);
    wait_for_results();

    // random traffic under each pacing mix
    for (int p = 0; p < 4; p++) begin
      gap_pct   = gap_plan[p];
      stall_pct = stall_plan[p];
      run_random(PHASE_ITEMS);
      wait_for_results();
    end

    // let anything stray show up before the verdict
    stall_pct = 0;
    repeat (10) @(posedge clk);

    $display("covered %0d samples and %0d clears, %0d results checked, ring wrapped %0d times",
             sb.adds, sb.clears, sb.checked, sb.wraps);
    $display("pacing: free flow, sender gaps, receiver stalls and light mixed idling");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/wma_pkg.sv
sv/wma_ring.sv
sv/wma_update.sv
sv/wma_divide.sv
sv/weighted_moving_average.sv
sv/wma_checker.sv
test/weighted_moving_average_tb.sv
